FILE: rtl/stable_priority_queue_macros.svh
// Assertion macros for the queue RTL
`ifndef STABLE_PRIORITY_QUEUE_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on clk, masked during reset
`define SPQ_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, masked during reset
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/spq_pkg.sv
package spq_pkg;

    localparam int KeyW    = 32;
    localparam int AgeW    = 8;
    localparam int LvlW    = 2;
    localparam int StatusW = 3;
    localparam int FillW   = 5;

    // Action codes of the input item
    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_LIST   = 2'd2;

    // Result status codes
    localparam logic [StatusW-1:0] ST_INSERTED  = 3'd0;
    localparam logic [StatusW-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [StatusW-1:0] ST_FULL      = 3'd2;
    localparam logic [StatusW-1:0] ST_BADLEVEL  = 3'd3;
    localparam logic [StatusW-1:0] ST_ENTRY     = 3'd4;
    localparam logic [StatusW-1:0] ST_EMPTY     = 3'd5;

    // One queue entry as held by a cell
    typedef struct packed {
        logic [KeyW-1:0] key;
        logic [AgeW-1:0] age;
        logic [LvlW-1:0] lvl;
    } spq_entry_t;

    // Command broadcast along the chain
    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_CHECK,
        CMD_INSERT,
        CMD_REMOVE,
        CMD_ROTATE
    } spq_cmd_t;

    typedef struct packed {
        spq_cmd_t   cmd;
        spq_entry_t entry;
    } spq_ctrl_t;

endpackage

FILE: rtl/spq_cell.sv
module spq_cell (
    input  logic               clk,
    input  spq_pkg::spq_ctrl_t ctrl,
    input  logic               occupied,
    input  logic               right_occ,
    input  logic               left_ge,
    input  spq_pkg::spq_entry_t left_data,
    input  spq_pkg::spq_entry_t right_data,
    input  spq_pkg::spq_entry_t front_data,
    output spq_pkg::spq_entry_t data,
    output logic               ge,
    output logic               match
);

    spq_pkg::spq_entry_t data_reg;
    spq_pkg::spq_entry_t data_next;
    logic                ge_reg;
    logic                ge_next;
    logic                match_reg;
    logic                match_next;

    // Pick the next content of this cell from the broadcast command
    always_comb
    begin
        data_next  = data_reg;
        ge_next    = ge_reg;
        match_next = match_reg;
        unique case (ctrl.cmd)
            spq_pkg::CMD_CHECK:
            begin
                ge_next    = occupied && (data_reg.lvl >= ctrl.entry.lvl);
                match_next = occupied && (data_reg.key == ctrl.entry.key);
            end
            spq_pkg::CMD_INSERT:
            begin
                // keep entries of equal or higher level, open a slot after them
                if (!ge_reg)
                begin
                    data_next = left_ge ? ctrl.entry : left_data;
                end
            end
            spq_pkg::CMD_REMOVE:
            begin
                data_next = right_data;
            end
            spq_pkg::CMD_ROTATE:
            begin
                // the last occupied cell wraps the front entry round
                if (right_occ)
                begin
                    data_next = right_data;
                end
                else if (occupied)
                begin
                    data_next = front_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    // Hold entry and compare flags
    always_ff @(posedge clk)
    begin
        data_reg  <= data_next;
        ge_reg    <= ge_next;
        match_reg <= match_next;
    end

    assign data  = data_reg;
    assign ge    = ge_reg;
    assign match = match_reg;

endmodule

FILE: rtl/stable_priority_queue.sv
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid, in_stall | action, entry_id, entry_age, level
// out     | output    | out_valid, out_stall | status, out_id, out_age, out_level, fill, last
//
// Insert first compares the new key and level in every cell, then shifts the
// chain open. Remove shifts the front entry out of the chain. List rotates
// the chain once per listed entry, and the chain is whole again at the end;
// an empty queue gives a single empty result.
// One item is worked on at a time; in_stall is high from transfer to last result.
// A stalled output holds the chain. Reset clears the fill count and the control.
module stable_priority_queue #(
    parameter int DEPTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     action,
    input  logic [spq_pkg::KeyW-1:0]       entry_id,
    input  logic [spq_pkg::AgeW-1:0]       entry_age,
    input  logic [spq_pkg::LvlW-1:0]       level,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [spq_pkg::StatusW-1:0]    status,
    output logic [spq_pkg::KeyW-1:0]       out_id,
    output logic [spq_pkg::AgeW-1:0]       out_age,
    output logic [spq_pkg::LvlW-1:0]       out_level,
    output logic [spq_pkg::FillW-1:0]      fill,
    output logic                           last
);

    `include "stable_priority_queue_macros.svh"

    localparam int OW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_INSERT,
        S_REMOVE,
        S_LIST
    } state_t;

    state_t                           state_reg;
    logic [OW-1:0]                    occ_reg;
    logic [OW-1:0]                    occ_next;
    logic [OW-1:0]                    cnt_reg;
    logic [spq_pkg::KeyW-1:0]         id_reg;
    logic [spq_pkg::AgeW-1:0]         age_reg;
    logic [spq_pkg::LvlW-1:0]         lvl_reg;
    logic                             out_valid_reg;
    logic [spq_pkg::StatusW-1:0]      status_reg;
    logic [spq_pkg::KeyW-1:0]         out_id_reg;
    logic [spq_pkg::AgeW-1:0]         out_age_reg;
    logic [spq_pkg::LvlW-1:0]         out_level_reg;
    logic [spq_pkg::FillW-1:0]        fill_reg;
    logic                             last_reg;

    spq_pkg::spq_ctrl_t               ctrl;
    spq_pkg::spq_entry_t              cell_data [DEPTH];
    logic [DEPTH-1:0]                 occ_vec;
    logic [DEPTH-1:0]                 ge_vec;
    logic [DEPTH-1:0]                 match_vec;
    logic                             out_free;
    logic                             dup;
    logic                             full;
    logic                             empty;
    logic                             list_end;

    assign out_free = !out_valid_reg || !out_stall;
    assign dup      = |match_vec;
    assign full     = (occ_reg == OW'(DEPTH));
    assign empty    = (occ_reg == '0);
    assign list_end = (cnt_reg == OW'(occ_reg - 1'b1));

    // Broadcast command and new entry to the chain
    always_comb
    begin
        ctrl.cmd   = spq_pkg::CMD_HOLD;
        ctrl.entry = '{key: id_reg, age: age_reg, lvl: lvl_reg};
        unique case (state_reg)
            S_IDLE:
            begin
                ctrl.entry = '{key: entry_id, age: entry_age, lvl: level};
                if (in_valid && (action == spq_pkg::ACT_INSERT))
                begin
                    ctrl.cmd = spq_pkg::CMD_CHECK;
                end
            end
            S_INSERT:
            begin
                if (out_free && !dup && (lvl_reg != '0) && !full)
                begin
                    ctrl.cmd = spq_pkg::CMD_INSERT;
                end
            end
            S_REMOVE:
            begin
                if (out_free && !empty)
                begin
                    ctrl.cmd = spq_pkg::CMD_REMOVE;
                end
            end
            S_LIST:
            begin
                if (out_free && !empty)
                begin
                    ctrl.cmd = spq_pkg::CMD_ROTATE;
                end
            end
            default:
            begin
                ctrl.cmd = spq_pkg::CMD_HOLD;
            end
        endcase
    end

    // Fill count after this step
    always_comb
    begin
        unique case (ctrl.cmd)
            spq_pkg::CMD_INSERT: occ_next = OW'(occ_reg + 1'b1);
            spq_pkg::CMD_REMOVE: occ_next = OW'(occ_reg - 1'b1);
            default:             occ_next = occ_reg;
        endcase
    end

    // Row of cells, front at index 0
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        localparam int L = (i == 0) ? 0 : i - 1;
        localparam int R = (i == DEPTH - 1) ? DEPTH - 1 : i + 1;

        assign occ_vec[i] = (occ_reg > OW'(i));

        spq_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .occupied   (occ_vec[i]),
            .right_occ  ((i == DEPTH - 1) ? 1'b0 : occ_vec[R]),
            .left_ge    ((i == 0) ? 1'b1 : ge_vec[L]),
            .left_data  (cell_data[L]),
            .right_data (cell_data[R]),
            .front_data (cell_data[0]),
            .data       (cell_data[i]),
            .ge         (ge_vec[i]),
            .match      (match_vec[i])
        );
    end

    // Sequence the item and load the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            occ_reg       <= '0;
            cnt_reg       <= '0;
            id_reg        <= '0;
            age_reg       <= '0;
            lvl_reg       <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= '0;
            out_id_reg    <= '0;
            out_age_reg   <= '0;
            out_level_reg <= '0;
            fill_reg      <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
            // every busy state loads one result whenever the output is free
            if (out_free)
            begin
                out_valid_reg <= (state_reg != S_IDLE);
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        id_reg  <= entry_id;
                        age_reg <= entry_age;
                        lvl_reg <= level;
                        cnt_reg <= '0;
                        priority case (action)
                            spq_pkg::ACT_INSERT: state_reg <= S_INSERT;
                            spq_pkg::ACT_REMOVE: state_reg <= S_REMOVE;
                            spq_pkg::ACT_LIST:   state_reg <= S_LIST;
                            default:             state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_INSERT:
                begin
                    if (out_free)
                    begin
                        out_id_reg    <= '0;
                        out_age_reg   <= '0;
                        out_level_reg <= '0;
                        fill_reg      <= spq_pkg::FillW'(occ_next);
                        last_reg      <= 1'b1;
                        if (dup)
                        begin
                            status_reg <= spq_pkg::ST_DUPLICATE;
                        end
                        else if (lvl_reg == '0)
                        begin
                            status_reg <= spq_pkg::ST_BADLEVEL;
                        end
                        else if (full)
                        begin
                            status_reg <= spq_pkg::ST_FULL;
                        end
                        else
                        begin
                            status_reg <= spq_pkg::ST_INSERTED;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                S_REMOVE, S_LIST:
                begin
                    if (out_free)
                    begin
                        fill_reg      <= spq_pkg::FillW'(occ_next);
                        if (empty)
                        begin
                            status_reg    <= spq_pkg::ST_EMPTY;
                            out_id_reg    <= '0;
                            out_age_reg   <= '0;
                            out_level_reg <= '0;
                            last_reg      <= 1'b1;
                            state_reg     <= S_IDLE;
                        end
                        else
                        begin
                            status_reg    <= spq_pkg::ST_ENTRY;
                            out_id_reg    <= cell_data[0].key;
                            out_age_reg   <= cell_data[0].age;
                            out_level_reg <= cell_data[0].lvl;
                            cnt_reg       <= OW'(cnt_reg + 1'b1);
                            if ((state_reg == S_REMOVE) || list_end)
                            begin
                                last_reg  <= 1'b1;
                                state_reg <= S_IDLE;
                            end
                            else
                            begin
                                last_reg <= 1'b0;
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign out_id    = out_id_reg;
    assign out_age   = out_age_reg;
    assign out_level = out_level_reg;
    assign fill      = fill_reg;
    assign last      = last_reg;

    // Checks on fill count and result contents
    `SPQ_ASSERT_IMPL(a_occ_bound, 1'b1, occ_reg <= OW'(DEPTH), "fill count above depth")
    `SPQ_ASSERT_NEXT(a_remove_drops, (state_reg == S_REMOVE) && out_free && !empty,
        occ_reg == OW'($past(occ_reg) - 1'b1), "remove did not drop one entry")
    `SPQ_ASSERT_IMPL(a_entry_level, out_valid_reg && (status_reg == spq_pkg::ST_ENTRY),
        out_level_reg != '0, "given entry has level zero")
    `SPQ_ASSERT_IMPL(a_empty_fill, out_valid_reg && (status_reg == spq_pkg::ST_EMPTY),
        (fill_reg == '0) && last_reg, "empty result with entries held")

endmodule
